@@ design/spm_pkg.sv @@
`default_nettype none
package spm_pkg;

	localparam int MAX_TERMS = 8;
	localparam int MAX_EXP = 255;
	localparam int SLOTS = 2 * MAX_EXP + 1;

	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int SLOT_W = $clog2(SLOTS);

	localparam int KIND_W = 3;
	localparam int COEF_W = 16;
	localparam int EXP_W = 8;
	localparam int PROD_W = 2 * COEF_W;
	localparam int SUM_W = 38;
	localparam int OEXP_W = 9;

	localparam logic [KIND_W-1:0] KIND_ADD_A = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADD_B = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLR_A = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLR_B = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MUL = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic signed [COEF_W-1:0] coefficient;
		logic [EXP_W-1:0] exponent;
	} cmd_word_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] product_coefficient;
		logic [OEXP_W-1:0] product_exponent;
		logic last;
		logic empty_res;
	} res_word_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient;
		logic [EXP_W-1:0] exponent;
	} term_t;

	typedef struct packed {
		logic wr_a;
		logic wr_b;
		logic clr_a;
		logic clr_b;
	} store_ctl_t;

	typedef struct packed {
		logic used;
		logic signed [SUM_W-1:0] sum;
	} acc_entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_TERMS,
		ST_RD_ACC,
		ST_WR_ACC,
		ST_SCAN,
		ST_FLUSH,
		ST_LAST
	} state_t;

endpackage
`default_nettype wire

@@ design/spm_terms.sv @@
`default_nettype none
module spm_terms (
	input wire logic clk,
	input wire logic arst_n,
	input wire spm_pkg::store_ctl_t ctl,
	input wire spm_pkg::term_t wr_term,
	input wire logic [spm_pkg::IDX_W-1:0] rd_i,
	input wire logic [spm_pkg::IDX_W-1:0] rd_j,
	output logic [spm_pkg::CNT_W-1:0] cnt_a,
	output logic [spm_pkg::CNT_W-1:0] cnt_b,
	output spm_pkg::term_t term_a,
	output spm_pkg::term_t term_b
);
	import spm_pkg::*;

	term_t mem_a [MAX_TERMS];
	term_t mem_b [MAX_TERMS];
	logic exp_ok;
	logic wr_a_ok;
	logic wr_b_ok;

	assign exp_ok = int'(wr_term.exponent) <= MAX_EXP;
	assign wr_a_ok = ctl.wr_a && exp_ok && (cnt_a < CNT_W'(MAX_TERMS));
	assign wr_b_ok = ctl.wr_b && exp_ok && (cnt_b < CNT_W'(MAX_TERMS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a <= '0;
			cnt_b <= '0;
		end else begin
			if (ctl.clr_a) begin
				cnt_a <= '0;
			end else if (wr_a_ok) begin
				cnt_a <= cnt_a + CNT_W'(1);
			end
			if (ctl.clr_b) begin
				cnt_b <= '0;
			end else if (wr_b_ok) begin
				cnt_b <= cnt_b + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_a_ok) begin
			mem_a[cnt_a[IDX_W-1:0]] <= wr_term;
		end
		if (wr_b_ok) begin
			mem_b[cnt_b[IDX_W-1:0]] <= wr_term;
		end
		term_a <= mem_a[rd_i];
		term_b <= mem_b[rd_j];
	end

endmodule
`default_nettype wire

@@ design/spm_acc_ram.sv @@
`default_nettype none
module spm_acc_ram (
	input wire logic clk,
	input wire logic [spm_pkg::SLOT_W-1:0] rd_addr,
	output spm_pkg::acc_entry_t rd_data,
	input wire logic wr_en,
	input wire logic [spm_pkg::SLOT_W-1:0] wr_addr,
	input wire spm_pkg::acc_entry_t wr_data
);
	import spm_pkg::*;

	acc_entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

@@ design/sparse_polynomial_multiply.sv @@
`default_nettype none
// Sparse polynomial multiplier.
// A command word is taken at a rising edge where start is high and busy is low.
// Loading a term into store A or B, or clearing a store, leaves busy low, so
// such words may follow one another in consecutive cycles.
// A multiply command raises busy. Each pair of terms is handled in turn in the
// accumulator memory (read the terms, read the slot, write the slot back), and
// then all 511 exponent slots are scanned in descending order, one slot per
// cycle through the single read port, with each slot cleared as it is read.
// Each result word appears on res for exactly one cycle, marked by strobe;
// the final word of a multiply has last set. If either store is empty, a single
// word with empty_res and last set follows in the cycle after the command and
// busy stays low. The receiver cannot stall the block and must take every word.
// After reset both stores are empty and the accumulator memory is cleared by a
// pass over all 511 slots, during which busy is high.
module sparse_polynomial_multiply (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire spm_pkg::cmd_word_t cmd,
	output logic busy,
	output logic strobe,
	output spm_pkg::res_word_t res
);
	import spm_pkg::*;

	state_t state_q;
	state_t state_d;
	store_ctl_t ctl;
	term_t wr_term;
	term_t term_a;
	term_t term_b;
	logic [CNT_W-1:0] cnt_a;
	logic [CNT_W-1:0] cnt_b;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic last_i;
	logic last_j;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] pair_exp;
	logic [SLOT_W-1:0] addr_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0] prod_ext;
	logic [SLOT_W-1:0] acc_rd_addr;
	acc_entry_t acc_rd;
	logic acc_wr_en;
	logic [SLOT_W-1:0] acc_wr_addr;
	acc_entry_t acc_wr_data;
	logic scan_vld_s1;
	logic [SLOT_W-1:0] scan_addr_s1;
	logic hold_vld_q;
	logic signed [SUM_W-1:0] hold_coef_q;
	logic [SLOT_W-1:0] hold_exp_q;
	logic emit_empty;
	logic emit_last;
	logic scan_emit;
	logic scan_hit;

	assign wr_term.coefficient = cmd.coefficient;
	assign wr_term.exponent = cmd.exponent;

	spm_terms u_terms (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.wr_term(wr_term),
		.rd_i(i_q),
		.rd_j(j_q),
		.cnt_a(cnt_a),
		.cnt_b(cnt_b),
		.term_a(term_a),
		.term_b(term_b)
	);

	spm_acc_ram u_acc_ram (
		.clk(clk),
		.rd_addr(acc_rd_addr),
		.rd_data(acc_rd),
		.wr_en(acc_wr_en),
		.wr_addr(acc_wr_addr),
		.wr_data(acc_wr_data)
	);

	assign pair_exp = SLOT_W'(term_a.exponent) + SLOT_W'(term_b.exponent);
	assign prod_ext = {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign last_i = (CNT_W'(i_q) + CNT_W'(1)) == cnt_a;
	assign last_j = (CNT_W'(j_q) + CNT_W'(1)) == cnt_b;
	assign scan_hit = scan_vld_s1 && acc_rd.used;
	assign scan_emit = scan_hit && hold_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		ctl = '0;
		acc_rd_addr = slot_q;
		acc_wr_en = 1'b0;
		acc_wr_addr = slot_q;
		acc_wr_data = '0;
		emit_empty = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				acc_wr_en = 1'b1;
				if (slot_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					unique case (cmd.kind)
						KIND_ADD_A: ctl.wr_a = 1'b1;
						KIND_ADD_B: ctl.wr_b = 1'b1;
						KIND_CLR_A: ctl.clr_a = 1'b1;
						KIND_CLR_B: ctl.clr_b = 1'b1;
						KIND_MUL: begin
							if (cnt_a == '0 || cnt_b == '0) begin
								emit_empty = 1'b1;
							end else begin
								state_d = ST_RD_TERMS;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RD_TERMS: begin
				state_d = ST_RD_ACC;
			end
			ST_RD_ACC: begin
				acc_rd_addr = pair_exp;
				state_d = ST_WR_ACC;
			end
			ST_WR_ACC: begin
				acc_wr_en = 1'b1;
				acc_wr_addr = addr_q;
				acc_wr_data.used = 1'b1;
				acc_wr_data.sum = acc_rd.sum + prod_ext;
				state_d = (last_i && last_j) ? ST_SCAN : ST_RD_TERMS;
			end
			ST_SCAN: begin
				if (slot_q == '0) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_LAST;
			end
			ST_LAST: begin
				emit_last = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (scan_vld_s1) begin
			acc_wr_en = 1'b1;
			acc_wr_addr = scan_addr_s1;
			acc_wr_data = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_W'(SLOTS - 1);
			i_q <= '0;
			j_q <= '0;
			scan_vld_s1 <= 1'b0;
			hold_vld_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			scan_vld_s1 <= state_q == ST_SCAN;
			strobe <= emit_empty || emit_last || scan_emit;
			if ((state_q == ST_CLEAR || state_q == ST_SCAN) && slot_q != '0) begin
				slot_q <= slot_q - SLOT_W'(1);
			end
			if (state_q == ST_IDLE) begin
				i_q <= '0;
				j_q <= '0;
			end
			if (state_q == ST_WR_ACC) begin
				if (last_j) begin
					j_q <= '0;
					if (last_i) begin
						slot_q <= SLOT_W'(SLOTS - 1);
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
			if (scan_hit) begin
				hold_vld_q <= 1'b1;
			end else if (emit_last) begin
				hold_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD_ACC) begin
			prod_q <= PROD_W'(term_a.coefficient * term_b.coefficient);
			addr_q <= pair_exp;
		end
		scan_addr_s1 <= slot_q;
		if (scan_hit) begin
			hold_coef_q <= acc_rd.sum;
			hold_exp_q <= scan_addr_s1;
		end
		if (emit_empty) begin
			res <= '{product_coefficient: '0, product_exponent: '0, last: 1'b1,
				empty_res: 1'b1};
		end else begin
			res.product_coefficient <= hold_coef_q;
			res.product_exponent <= OEXP_W'(hold_exp_q);
			res.last <= emit_last;
			res.empty_res <= 1'b0;
		end
	end

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && res.empty_res |-> res.last)
		else $error("Empty result word without last.");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR_ACC |-> $past(state_q == ST_RD_ACC))
		else $error("Accumulator write-back without a preceding slot read.");

	a_scan_window: assert property (@(posedge clk) disable iff (!arst_n)
		scan_vld_s1 |-> (state_q == ST_SCAN || state_q == ST_FLUSH))
		else $error("Scan clearing write outside the scan.");

	a_last_after_flush: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LAST |-> hold_vld_q)
		else $error("Final word of a multiply has nothing held.");

endmodule
`default_nettype wire
